/* hdl/tvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tvc_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam int TTL_W = 63;
    localparam logic [TTL_W-1:0] TTL_RESET = 63'd3000000000;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_RECORD = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } tvc_state_t;

    typedef struct packed {
        logic [31:0] source;
        logic [31:0] target;
        logic [63:0] created;
        logic [31:0] rights;
        logic [63:0] granted;
    } tvc_entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic write;
        logic resp_push;
    } tvc_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic is_record;
        logic out_free;
    } tvc_status_t;

endpackage

`default_nettype wire

/* hdl/tvc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tvc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic [1:0]         s_opcode,
    output logic                    s_ready,
    input  wire tvc_pkg::tvc_status_t status,
    output tvc_pkg::tvc_cmd_t       cmd
);

    tvc_pkg::tvc_state_t state_reg;
    tvc_pkg::tvc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tvc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tvc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == tvc_pkg::OP_LOOKUP || s_opcode == tvc_pkg::OP_RECORD) begin
                        state_next = tvc_pkg::ST_SCAN;
                    end else begin
                        state_next = tvc_pkg::ST_RESP;
                    end
                end
            end
            tvc_pkg::ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = status.is_record ? tvc_pkg::ST_WRITE : tvc_pkg::ST_RESP;
                end
            end
            tvc_pkg::ST_WRITE: begin
                state_next = tvc_pkg::ST_RESP;
            end
            tvc_pkg::ST_RESP: begin
                if (status.out_free) begin
                    state_next = tvc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.load      = 1'b0;
        cmd.scan      = 1'b0;
        cmd.write     = 1'b0;
        cmd.resp_push = 1'b0;
        unique case (state_reg)
            tvc_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            tvc_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            tvc_pkg::ST_WRITE: begin
                cmd.write = 1'b1;
            end
            tvc_pkg::ST_RESP: begin
                cmd.resp_push = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/tvc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module tvc_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tvc_pkg::tvc_cmd_t           cmd,
    output tvc_pkg::tvc_status_t             status,
    input  wire logic [1:0]                  s_opcode,
    input  wire logic [31:0]                 s_source_id,
    input  wire logic [31:0]                 s_target_id,
    input  wire logic [63:0]                 s_target_time,
    input  wire logic [31:0]                 s_perm_mask,
    input  wire logic signed [63:0]          s_now_time,
    input  wire logic                        cfg_write,
    input  wire logic [tvc_pkg::TTL_W-1:0]   cfg_ttl_ticks,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_hit
);

    localparam int IW = tvc_pkg::IDX_W;
    localparam int CW = tvc_pkg::CNT_W;

    tvc_pkg::tvc_entry_t mem [tvc_pkg::SLOT_COUNT];
    tvc_pkg::tvc_entry_t rd_data_reg;

    logic [tvc_pkg::SLOT_COUNT-1:0] valid_bits_reg;
    logic [tvc_pkg::TTL_W-1:0]      ttl_reg;

    logic [1:0]  op_reg;
    logic [31:0] source_reg;
    logic [31:0] target_reg;
    logic [63:0] created_reg;
    logic [31:0] mask_reg;
    logic [63:0] now_reg;

    logic [CW-1:0] rd_cnt_reg;
    logic          eval_valid_reg;
    logic [IW-1:0] eval_idx_reg;

    logic          hit_reg;
    logic          match_found_reg;
    logic [IW-1:0] match_idx_reg;
    logic [31:0]   match_rights_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic [IW-1:0] oldest_idx_reg;
    logic [63:0]   oldest_time_reg;

    logic          m_valid_reg;
    logic          m_hit_reg;

    logic          rd_en;
    logic          eval_en;
    logic          slot_valid;
    logic          key_eq;
    logic          slot_match;
    logic [64:0]   age;
    logic          slot_expired;
    logic          slot_covers;
    logic          lookup_hit;
    logic          older;
    logic          is_record;
    logic [IW-1:0] wr_idx;
    tvc_pkg::tvc_entry_t wr_entry;

    assign is_record = (op_reg == tvc_pkg::OP_RECORD);
    assign rd_en     = cmd.scan && (rd_cnt_reg < CW'(tvc_pkg::SLOT_COUNT));
    assign eval_en   = cmd.scan && eval_valid_reg;

    assign slot_valid = valid_bits_reg[eval_idx_reg];
    assign key_eq     = (rd_data_reg.source == source_reg) &&
                        (rd_data_reg.target == target_reg) &&
                        (rd_data_reg.created == created_reg);
    assign slot_match = slot_valid && key_eq;

    // The age is taken as an exact signed difference, one bit wider than a time.
    assign age          = {now_reg[63], now_reg} - {rd_data_reg.granted[63], rd_data_reg.granted};
    assign slot_expired = $signed(age) > $signed({2'b00, ttl_reg});
    assign slot_covers  = (mask_reg & ~rd_data_reg.rights) == 32'd0;
    assign lookup_hit   = !is_record && slot_match && !slot_expired && slot_covers;
    assign older        = $signed(rd_data_reg.granted) < $signed(oldest_time_reg);

    assign status.scan_done = eval_en && (lookup_hit || eval_idx_reg == IW'(tvc_pkg::SLOT_COUNT - 1));
    assign status.is_record = is_record;
    assign status.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        if (match_found_reg) begin
            wr_idx = match_idx_reg;
        end else if (free_found_reg) begin
            wr_idx = free_idx_reg;
        end else begin
            wr_idx = oldest_idx_reg;
        end
        wr_entry.source  = source_reg;
        wr_entry.target  = target_reg;
        wr_entry.created = created_reg;
        wr_entry.rights  = match_found_reg ? (match_rights_reg | mask_reg) : mask_reg;
        wr_entry.granted = now_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_cnt_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_opcode;
            source_reg  <= s_source_id;
            target_reg  <= s_target_id;
            created_reg <= s_target_time;
            mask_reg    <= s_perm_mask;
            now_reg     <= s_now_time;
        end
        if (rd_en) begin
            eval_idx_reg <= rd_cnt_reg[IW-1:0];
        end
        if (eval_en && slot_match && !match_found_reg) begin
            match_idx_reg    <= eval_idx_reg;
            match_rights_reg <= rd_data_reg.rights;
        end
        if (eval_en && !slot_valid && !free_found_reg) begin
            free_idx_reg <= eval_idx_reg;
        end
        if (eval_en && slot_valid && !free_found_reg &&
            (eval_idx_reg == '0 || older)) begin
            oldest_idx_reg  <= eval_idx_reg;
            oldest_time_reg <= rd_data_reg.granted;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_bits_reg  <= '0;
            ttl_reg         <= tvc_pkg::TTL_RESET;
            rd_cnt_reg      <= '0;
            eval_valid_reg  <= 1'b0;
            hit_reg         <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_hit_reg       <= 1'b0;
        end else begin
            if (cfg_write) begin
                ttl_reg <= cfg_ttl_ticks;
            end
            if (cmd.load) begin
                rd_cnt_reg      <= '0;
                eval_valid_reg  <= 1'b0;
                hit_reg         <= 1'b0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                if (s_opcode == tvc_pkg::OP_CLEAR) begin
                    valid_bits_reg <= '0;
                end
            end else begin
                if (cmd.scan) begin
                    eval_valid_reg <= rd_en;
                end
                if (rd_en) begin
                    rd_cnt_reg <= rd_cnt_reg + CW'(1);
                end
                if (eval_en) begin
                    if (!is_record && slot_match && slot_expired) begin
                        valid_bits_reg[eval_idx_reg] <= 1'b0;
                    end
                    if (lookup_hit) begin
                        hit_reg <= 1'b1;
                    end
                    if (slot_match) begin
                        match_found_reg <= 1'b1;
                    end
                    if (!slot_valid) begin
                        free_found_reg <= 1'b1;
                    end
                end
                if (cmd.write) begin
                    valid_bits_reg[wr_idx] <= 1'b1;
                end
            end
            if (cmd.resp_push) begin
                m_valid_reg <= 1'b1;
                m_hit_reg   <= hit_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;

endmodule

`default_nettype wire

/* hdl/ttl_verdict_cache.sv */
// Verdict cache with one shared entry lifetime, 64 slots scanned one per cycle.
// Input channel s_*: one item per handshake, s_opcode selects lookup,
// record or clear; an unused opcode changes nothing and answers a miss.
// Result channel m_*: exactly one item per input item, carrying m_hit.
// Configuration channel cfg_*: writes the entry lifetime, always ready;
// write it only while the block is idle.
// A lookup or record scans the slots in order, a lookup stopping at its
// first hit, and a record then writes its slot; a clear or unused opcode
// goes straight to the response. The slot store is a single-port-read
// memory read one entry per cycle, so the scan length sets how long an item takes.
// One item at a time; s_ready is high only between items, and the next
// item can be taken in the cycle after its result is registered.
// A finished result sits in the output register, and the next item is
// accepted while it waits; a later result holds back until m_ready frees it.
// Reset (aresetn low, synchronous) marks all slots free, restores the
// lifetime to 3000000000 ticks and drops m_valid. No clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module ttl_verdict_cache (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_opcode,
    input  wire logic [31:0]               s_source_id,
    input  wire logic [31:0]               s_target_id,
    input  wire logic [63:0]               s_target_time,
    input  wire logic [31:0]               s_perm_mask,
    input  wire logic signed [63:0]        s_now_time,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_hit,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [tvc_pkg::TTL_W-1:0] cfg_ttl_ticks
);

    tvc_pkg::tvc_cmd_t    cmd;
    tvc_pkg::tvc_status_t status;

    assign cfg_ready = 1'b1;

    tvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tvc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_opcode      (s_opcode),
        .s_source_id   (s_source_id),
        .s_target_id   (s_target_id),
        .s_target_time (s_target_time),
        .s_perm_mask   (s_perm_mask),
        .s_now_time    (s_now_time),
        .cfg_write     (cfg_valid & cfg_ready),
        .cfg_ttl_ticks (cfg_ttl_ticks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit)
    );

endmodule

`default_nettype wire

/* hdl/tvc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tvc_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_hit,
    input wire logic cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit))
        else $error("Result item changed while stalled.");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Second item accepted while one is in work.");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("Block not idle after reset.");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("Configuration channel not ready.");

endmodule

bind ttl_verdict_cache tvc_checker u_tvc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_hit     (m_hit),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0]                  OP_UNUSED    = 2'd3;
    localparam logic signed [63:0]          TIME_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]          TIME_MIN     = 64'sh8000_0000_0000_0000;
    localparam logic [tvc_pkg::TTL_W-1:0]   LIFETIME_MAX = '1;
    localparam int                          DRAIN_CYCLES = 80;

    typedef struct {
        logic [1:0]         opcode;
        logic [31:0]        source_id;
        logic [31:0]        target_id;
        logic [63:0]        target_time;
        logic [31:0]        perm_mask;
        logic signed [63:0] now_time;
    } access_req_t;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_opcode      = tvc_pkg::OP_LOOKUP;
    logic [31:0]              s_source_id   = '0;
    logic [31:0]              s_target_id   = '0;
    logic [63:0]              s_target_time = '0;
    logic [31:0]              s_perm_mask   = '0;
    logic signed [63:0]       s_now_time    = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic                     m_hit;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [tvc_pkg::TTL_W-1:0] cfg_ttl_ticks = '0;

    logic                     cached_valid   [tvc_pkg::SLOT_COUNT];
    logic [31:0]              cached_source  [tvc_pkg::SLOT_COUNT];
    logic [31:0]              cached_target  [tvc_pkg::SLOT_COUNT];
    logic [63:0]              cached_created [tvc_pkg::SLOT_COUNT];
    logic [31:0]              cached_rights  [tvc_pkg::SLOT_COUNT];
    logic signed [63:0]       cached_granted [tvc_pkg::SLOT_COUNT];
    logic [tvc_pkg::TTL_W-1:0] lifetime_model = tvc_pkg::TTL_RESET;

    access_req_t              pending_reqs[$];
    access_req_t              record_history[$];
    logic                     expected_hits[$];
    access_req_t              offered;
    bit                       item_pending = 1'b0;
    bit                       cfg_taken    = 1'b0;
    logic                     hit_wanted;

    logic [31:0]              source_pool  [4];
    logic [31:0]              target_pool  [4];
    logic [63:0]              created_pool [8];
    logic signed [63:0]       wall_clock = '0;

    int                       gap_pct   = 10;
    int                       stall_pct = 63;
    int                       mismatch_count = 0;
    int                       items_accepted = 0;
    int                       lookup_count   = 0;
    int                       hit_count      = 0;
    int                       expiry_count   = 0;
    int                       eviction_count = 0;

    ttl_verdict_cache dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_source_id   (s_source_id),
        .s_target_id   (s_target_id),
        .s_target_time (s_target_time),
        .s_perm_mask   (s_perm_mask),
        .s_now_time    (s_now_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_ttl_ticks (cfg_ttl_ticks)
    );

    always #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("tb: mismatch at %0t ns: %0s", $time, what);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void clear_cache_model();
        for (int i = 0; i < tvc_pkg::SLOT_COUNT; i++) begin
            cached_valid[i]   = 1'b0;
            cached_source[i]  = '0;
            cached_target[i]  = '0;
            cached_created[i] = '0;
            cached_rights[i]  = '0;
            cached_granted[i] = '0;
        end
    endfunction

    function automatic bit slot_matches(int idx, access_req_t r);
        return cached_valid[idx] && cached_source[idx] == r.source_id &&
               cached_target[idx] == r.target_id && cached_created[idx] == r.target_time;
    endfunction

    function automatic logic predict_verdict(access_req_t r);
        int          chosen;
        int          oldest;
        logic        verdict;
        logic [63:0] age;
        verdict = 1'b0;
        chosen  = -1;
        oldest  = 0;
        case (r.opcode)
            tvc_pkg::OP_LOOKUP: begin
                lookup_count++;
                for (int i = 0; i < tvc_pkg::SLOT_COUNT; i++) begin
                    if (slot_matches(i, r)) begin
                        age = r.now_time - cached_granted[i];
                        if (cached_granted[i] < r.now_time && age > {1'b0, lifetime_model}) begin
                            cached_valid[i] = 1'b0;
                            expiry_count++;
                        end else if ((r.perm_mask & ~cached_rights[i]) == '0) begin
                            verdict = 1'b1;
                            break;
                        end
                    end
                end
                if (verdict) begin
                    hit_count++;
                end
            end
            tvc_pkg::OP_RECORD: begin
                for (int i = 0; i < tvc_pkg::SLOT_COUNT; i++) begin
                    if (slot_matches(i, r)) begin
                        chosen = i;
                        break;
                    end
                end
                if (chosen >= 0) begin
                    cached_rights[chosen] |= r.perm_mask;
                    cached_granted[chosen] = r.now_time;
                end else begin
                    for (int i = 0; i < tvc_pkg::SLOT_COUNT; i++) begin
                        if (!cached_valid[i]) begin
                            chosen = i;
                            break;
                        end
                        if (cached_granted[i] < cached_granted[oldest]) begin
                            oldest = i;
                        end
                    end
                    if (chosen < 0) begin
                        chosen = oldest;
                        eviction_count++;
                    end
                    cached_valid[chosen]   = 1'b1;
                    cached_source[chosen]  = r.source_id;
                    cached_target[chosen]  = r.target_id;
                    cached_created[chosen] = r.target_time;
                    cached_rights[chosen]  = r.perm_mask;
                    cached_granted[chosen] = r.now_time;
                end
            end
            tvc_pkg::OP_CLEAR: begin
                clear_cache_model();
            end
            default: begin
            end
        endcase
        return verdict;
    endfunction

    function automatic access_req_t make_req(logic [1:0] op, logic [31:0] src,
                                             logic [31:0] tgt, logic [63:0] created,
                                             logic [31:0] mask, logic signed [63:0] stamp);
        access_req_t r;
        r.opcode      = op;
        r.source_id   = src;
        r.target_id   = tgt;
        r.target_time = created;
        r.perm_mask   = mask;
        r.now_time    = stamp;
        return r;
    endfunction

    // Keys mostly come from small pools so that lookups and records collide.
    function automatic access_req_t pooled_key();
        access_req_t r;
        r = make_req(tvc_pkg::OP_LOOKUP, source_pool[$urandom_range(3)],
                     target_pool[$urandom_range(3)], created_pool[$urandom_range(7)],
                     '0, '0);
        if ($urandom_range(9) == 0) begin
            r.source_id   = $urandom;
            r.target_time = rand64();
        end
        return r;
    endfunction

    task automatic queue_random_traffic(int count, logic [63:0] step_max);
        access_req_t        r;
        access_req_t        past;
        int                 roll;
        logic signed [63:0] stamp;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                stamp = rand64();
            end else if (roll < 14) begin
                stamp = wall_clock - 64'($urandom_range(50));
            end else begin
                wall_clock = wall_clock + (rand64() % (step_max + 64'd1));
                stamp = wall_clock;
            end
            roll = $urandom_range(999);
            if (roll < 5) begin
                r = make_req(tvc_pkg::OP_CLEAR, $urandom, $urandom, rand64(), $urandom, stamp);
            end else if (roll < 25) begin
                r = make_req(OP_UNUSED, $urandom, $urandom, rand64(), $urandom, stamp);
            end else if (roll < 425) begin
                r = pooled_key();
                r.opcode    = tvc_pkg::OP_RECORD;
                r.perm_mask = $urandom_range(1) ? $urandom : ($urandom & $urandom);
                r.now_time  = stamp;
                record_history.push_back(r);
                if (record_history.size() > 16) begin
                    void'(record_history.pop_front());
                end
            end else if (record_history.size() != 0 && $urandom_range(99) < 60) begin
                past = record_history[$urandom_range(record_history.size() - 1)];
                r = make_req(tvc_pkg::OP_LOOKUP, past.source_id, past.target_id,
                             past.target_time, past.perm_mask & $urandom, stamp);
            end else begin
                r = pooled_key();
                r.perm_mask = $urandom_range(3) == 0 ? '0 : ($urandom & $urandom & $urandom);
                r.now_time  = stamp;
            end
            pending_reqs.push_back(r);
        end
    endtask

    task automatic wait_for_drain();
        do begin
            @(negedge aclk);
        end while (pending_reqs.size() != 0 || item_pending || expected_hits.size() != 0);
    endtask

    task automatic write_lifetime(logic [tvc_pkg::TTL_W-1:0] value);
        @(negedge aclk);
        cfg_taken = 1'b0;
        cfg_valid     <= 1'b1;
        cfg_ttl_ticks <= value;
        do begin
            @(negedge aclk);
        end while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int gap, int stall, logic [tvc_pkg::TTL_W-1:0] lifetime,
                             int count, logic [63:0] step_max);
        gap_pct   = gap;
        stall_pct = stall;
        write_lifetime(lifetime);
        queue_random_traffic(count, step_max);
        wait_for_drain();
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
        if (!item_pending) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
                offered = pending_reqs.pop_front();
                item_pending = 1'b1;
                s_valid       <= 1'b1;
                s_opcode      <= offered.opcode;
                s_source_id   <= offered.source_id;
                s_target_id   <= offered.target_id;
                s_target_time <= offered.target_time;
                s_perm_mask   <= offered.perm_mask;
                s_now_time    <= offered.now_time;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    hit_wanted = expected_hits.pop_front();
                    if (m_hit !== hit_wanted) begin
                        report_mismatch($sformatf("hit %b, expected %b", m_hit, hit_wanted));
                    end
                end
            end
            if (s_valid && s_ready) begin
                item_pending = 1'b0;
                expected_hits.push_back(predict_verdict(offered));
                items_accepted++;
            end
            if (cfg_valid && cfg_ready) begin
                lifetime_model = cfg_ttl_ticks;
                cfg_taken = 1'b1;
            end
        end
    end

    initial begin : sequencer
        logic [31:0]        key_a_src;
        logic [31:0]        key_a_tgt;
        logic [63:0]        key_a_created;
        logic signed [63:0] ttl0;
        logic [31:0]        extra_id;
        key_a_src     = 32'h0000_0001;
        key_a_tgt     = 32'h0000_0002;
        key_a_created = 64'h1;
        ttl0          = {1'b0, tvc_pkg::TTL_RESET};
        extra_id      = 32'(tvc_pkg::SLOT_COUNT);
        clear_cache_model();
        source_pool  = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
        target_pool  = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
        created_pool = '{64'h0, '1, rand64(), rand64(), rand64(), rand64(), rand64(), rand64()};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, run under the lifetime left by reset.
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, '0, '0, '0, '0, '0));
        pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, key_a_src, key_a_tgt, key_a_created,
                                        32'h0F, 64'sd1000));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, key_a_src, key_a_tgt, key_a_created,
                                        32'h03, 64'sd1001));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, key_a_src, key_a_tgt, key_a_created,
                                        32'h10, 64'sd1001));
        pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, key_a_src, key_a_tgt, key_a_created,
                                        32'hF0, 64'sd2000));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, key_a_src, key_a_tgt, key_a_created,
                                        32'hFF, 64'sd2000 + ttl0));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, key_a_src, key_a_tgt, key_a_created,
                                        32'hFF, 64'sd2001 + ttl0));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, key_a_src, key_a_tgt, key_a_created,
                                        32'h00, 64'sd2000));
        pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, key_a_src, key_a_tgt, key_a_created,
                                        32'h01, 64'sd5000));
        pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, key_a_src, key_a_tgt, key_a_created,
                                        32'h02, 64'sd5100 + ttl0));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, key_a_src, key_a_tgt, key_a_created,
                                        32'h03, 64'sd5100 + ttl0));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, key_a_src, key_a_tgt, key_a_created,
                                        32'h03, '0));
        pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, '1, '1, '1, '1, TIME_MAX));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, '1, '1, '1, '1, TIME_MIN));
        pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, '0, '0, '0, 32'h8000_0000,
                                        TIME_MIN));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, '0, '0, '0, 32'h8000_0000,
                                        TIME_MAX));
        pending_reqs.push_back(make_req(OP_UNUSED, '1, '1, '1, '0, TIME_MAX));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, '1, '1, '1, '0, TIME_MAX));
        pending_reqs.push_back(make_req(tvc_pkg::OP_CLEAR, '1, '1, '1, '1, TIME_MAX));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, '1, '1, '1, '0, TIME_MAX));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, key_a_src, key_a_tgt, key_a_created,
                                        32'h00, 64'sd5100 + ttl0));
        pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, '0, '0, '0, '0, '0));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, '0, '0, '0, '0, '0));
        wait_for_drain();

        run_phase(10, 63, '0, 400, 64'd3);
        run_phase(63, 10, LIFETIME_MAX, 400, 64'h4000_0000_0000_0000);
        run_phase(0, 0, 63'($urandom_range(4000, 1)), 400, 64'd1000);

        gap_pct   = 0;
        stall_pct = 0;
        write_lifetime(63'd50);
        // A full table with equal grant times gives up its lowest slot first.
        pending_reqs.push_back(make_req(tvc_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
        for (int i = 0; i < tvc_pkg::SLOT_COUNT; i++) begin
            pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, 32'(i), ~32'(i), 64'(i),
                                            '1, TIME_MAX));
        end
        pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, extra_id, ~extra_id,
                                        {32'd0, extra_id}, '1, TIME_MAX));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, '0, '1, '0, '0, TIME_MAX));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, 32'd1, ~32'd1, 64'd1, '1,
                                        TIME_MAX));
        pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, extra_id, ~extra_id,
                                        {32'd0, extra_id}, '1, TIME_MAX));
        // A full table with scattered, tied grant times.
        pending_reqs.push_back(make_req(tvc_pkg::OP_CLEAR, '0, '0, '0, '0, '0));
        for (int i = 0; i < tvc_pkg::SLOT_COUNT; i++) begin
            pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, 32'(i), ~32'(i), 64'(i),
                                            $urandom, 64'($urandom_range(7)) - 64'd4));
        end
        for (int i = 0; i < 4; i++) begin
            pending_reqs.push_back(make_req(tvc_pkg::OP_RECORD, 32'(1000 + i), 32'(i),
                                            64'(i), $urandom, 64'sd5));
        end
        for (int i = 0; i < tvc_pkg::SLOT_COUNT; i++) begin
            pending_reqs.push_back(make_req(tvc_pkg::OP_LOOKUP, 32'(i), ~32'(i), 64'(i),
                                            '0, 64'sd5));
        end
        queue_random_traffic(200, 64'd20);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("tb: %0d items over five lifetime settings, from zero to the 63-bit maximum",
                 items_accepted);
        $display("tb: %0d of %0d lookups hit, %0d entries expired, %0d slots replaced",
                 hit_count, lookup_count, expiry_count, eviction_count);
        if (mismatch_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

/* filelist.f */
hdl/tvc_pkg.sv
hdl/tvc_ctrl.sv
hdl/tvc_datapath.sv
hdl/ttl_verdict_cache.sv
hdl/tvc_checker.sv
bench/tb.sv
